// ===== sv/tbeq_pkg.sv =====
// ----------------------------------------------------------------------------
// tbeq_pkg - shared types and constants of the three-band equalizer
// Action codes, state encodings, the MAC control group and the soft clip
// constants in Q8.24.
// ----------------------------------------------------------------------------
`default_nettype none

package tbeq_pkg;

    // Input item kinds
    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_COEF   = 2'd1,
        ACT_ENABLE = 2'd2
    } t_action;

    // Coefficients per biquad: b0, b1, b2, a1, a2
    localparam int NCOEF = 5;

    // Soft clip threshold (0.98 in Q8.24) and headroom up to full scale
    localparam logic [31:0] CLIP_T = 32'd16441672;
    localparam logic [18:0] CLIP_H = 19'd335544;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BAND,
        S_MAC,
        S_DRAIN,
        S_WB,
        S_CLIP,
        S_OUT
    } t_state;

    // Soft clip unit states
    typedef enum logic [1:0] {
        C_IDLE,
        C_MUL,
        C_DIV,
        C_END
    } t_clip_state;

    // Control group from the sequencer to the MAC
    typedef struct packed {
        logic clr;   // clear accumulator and product stage
        logic en;    // a product enters this cycle
        logic sub;   // the product is subtracted
    } t_mac_ctl;

endpackage

`default_nettype wire

// ===== sv/tbeq_if.sv =====
// ----------------------------------------------------------------------------
// tbeq_if - valid/ready channels of the equalizer
// Input item channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbeq_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  action;
    logic        [2:0]  chan;
    logic signed [15:0] sample_in;
    logic        [1:0]  band;
    logic        [2:0]  coef_index;
    logic signed [31:0] coef_value;
    logic               band_on;

    modport source (output valid, action, chan, sample_in, band, coef_index,
                    coef_value, band_on, input ready);
    modport sink   (input valid, action, chan, sample_in, band, coef_index,
                    coef_value, band_on, output ready);
endinterface

interface tbeq_out_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  chan_out;
    logic signed [15:0] sample_out;

    modport source (output valid, chan_out, sample_out, input ready);
    modport sink   (input valid, chan_out, sample_out, output ready);
endinterface

`default_nettype wire

// ===== sv/tbeq_ram.sv =====
// ----------------------------------------------------------------------------
// tbeq_ram - generic synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tbeq_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_we,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  wire logic [W-1:0]                      i_wdata,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output      logic [W-1:0]                      o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/tbeq_mac.sv =====
// ----------------------------------------------------------------------------
// tbeq_mac - shared multiply-accumulate of the biquad terms
// Q4.28 x Q8.24 product registered, floor-shifted by 4 and accumulated;
// the output is the sum rounded to Q8.24 and saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tbeq_mac (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tbeq_pkg::t_mac_ctl i_ctl,
    input  wire logic signed [31:0] i_coef,
    input  wire logic signed [31:0] i_data,
    output      logic signed [31:0] o_y
);
    import tbeq_pkg::*;

    logic signed [63:0] r_prod;
    logic               r_pv;
    logic               r_psub;
    logic signed [63:0] r_acc;
    logic signed [63:0] w_term;
    logic signed [63:0] w_rnd;
    logic signed [39:0] w_shr;

    // product stage
    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_data;
        if (!i_rst_n || i_ctl.clr) begin
            r_pv   <= 1'b0;
            r_psub <= 1'b0;
        end else begin
            r_pv   <= i_ctl.en;
            r_psub <= i_ctl.sub;
        end
    end

    // accumulate the floor-shifted term
    assign w_term = r_prod >>> 4;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_psub ? (r_acc - w_term) : (r_acc + w_term);
        end
    end

    // round to Q8.24 and saturate
    assign w_rnd = r_acc + 64'sd8388608;
    assign w_shr = w_rnd[63:24];

    always_comb begin
        if (w_shr > 40'sd2147483647) begin
            o_y = 32'sh7FFF_FFFF;
        end else if (w_shr < -40'sd2147483648) begin
            o_y = 32'sh8000_0000;
        end else begin
            o_y = w_shr[31:0];
        end
    end

endmodule

`default_nettype wire

// ===== sv/tbeq_clip.sv =====
// ----------------------------------------------------------------------------
// tbeq_clip - soft clipper and 16-bit conversion
// Above the threshold the excess is compressed by H*8d/(2^24+8d), computed
// by a restoring divider, one quotient bit per cycle; then rounded half away
// from zero to 16 bits and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module tbeq_clip (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_v,
    output      logic               o_done,
    output      logic signed [15:0] o_res
);
    import tbeq_pkg::*;

    t_clip_state r_state, n_state;
    logic        r_neg;
    logic [31:0] r_mag;
    logic [55:0] r_rem;
    logic [55:0] r_dsh;
    logic [18:0] r_q;
    logic [4:0]  r_cnt;
    logic [31:0] w_dt;
    logic [56:0] w_trial;
    logic [32:0] w_sum;
    logic [23:0] w_r;

    assign w_dt    = r_mag - CLIP_T;
    assign w_trial = {1'b0, r_rem} - {1'b0, r_dsh};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE:  if (i_start) n_state = C_MUL;
            C_MUL:   n_state = (r_mag > CLIP_T) ? C_DIV : C_END;
            C_DIV:   if (r_cnt == 5'd18) n_state = C_END;
            C_END:   n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                r_neg <= i_v[31];
                r_mag <= i_v[31] ? (32'd0 - 32'(i_v)) : 32'(i_v);
                r_cnt <= '0;
                r_q   <= '0;
            end
            C_MUL: begin
                // numerator H*8d and denominator (2^24+8d) aligned to the top bit
                r_rem <= 56'(CLIP_H) * 56'({w_dt, 3'b000});
                r_dsh <= 56'({36'(36'd16777216 + {1'b0, w_dt, 3'b000}), 18'd0});
            end
            C_DIV: begin
                if (!w_trial[56]) begin
                    r_rem <= w_trial[55:0];
                end
                r_q   <= {r_q[17:0], ~w_trial[56]};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd18) begin
                    r_mag <= CLIP_T + 32'({r_q[17:0], ~w_trial[56]});
                end
            end
            default: begin
            end
        endcase
    end

    // round half away from zero, saturate
    assign w_sum  = {1'b0, r_mag} + 33'd256;
    assign w_r    = w_sum[32:9];
    assign o_done = (r_state == C_END);

    always_comb begin
        if (r_neg) begin
            o_res = (w_r > 24'd32768) ? 16'sh8000 : 16'(16'd0 - w_r[15:0]);
        end else begin
            o_res = (w_r > 24'd32767) ? 16'sh7FFF : 16'(w_r[15:0]);
        end
    end

endmodule

`default_nettype wire

// ===== sv/three_band_biquad_eq_softclip_core.sv =====
// ----------------------------------------------------------------------------
// three_band_biquad_eq_softclip_core - three-band biquad EQ with soft clip
// Items arrive on i_in: an audio sample with its channel, a coefficient
// write or a band enable write. Each audio sample of a valid channel gives
// one transfer on o_out; writes and ignored items give none.
// One item is processed at a time, and a write is taken in the idle state.
// A sample passes a band check for each disabled band and, for each enabled
// band, the band check, the reads and five MACs through the single shared
// multiplier, one drain and four history write-backs; then, when any band
// is on, the soft clipper (multiply, 19 bit-serial divide steps, finish;
// only multiply and finish below the threshold), and last the final band
// check, the output state and the idle state that takes the item.
// The single read ports of the history and coefficient RAMs set this order.
// The finished result sits in an output register, so the next item is
// taken while it waits; a stalled receiver holds the block only when a
// second result is ready before the first is taken.
// Reset clears the band enables, the per-row history valid bits (history
// reads as zero until written) and the handshake state; coefficients are
// undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module three_band_biquad_eq_softclip_core #(
    parameter int CHANNELS = 8,
    parameter int BANDS    = 3
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tbeq_in_if.sink    i_in,
    tbeq_out_if.source o_out
);
    import tbeq_pkg::*;

    localparam int COEF_D = BANDS * NCOEF;
    localparam int ROWS   = CHANNELS * BANDS;
    localparam int HIST_D = ROWS * 4;
    localparam int CA_W   = $clog2(COEF_D);
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int HA_W   = ROW_W + 2;
    localparam int BC_W   = $clog2(BANDS + 1);
    localparam int BI_W   = (BANDS > 1) ? $clog2(BANDS) : 1;

    t_state             r_state, n_state;
    logic [BANDS-1:0]   r_en;
    logic [ROWS-1:0]    r_hval;
    logic [2:0]         r_chan;
    logic signed [15:0] r_sample;
    logic signed [31:0] r_x;
    logic [BC_W-1:0]    r_band;
    logic [2:0]         r_cnt;
    logic               r_touched;
    logic signed [31:0] r_h0;
    logic signed [31:0] r_h2;
    logic signed [15:0] r_res;
    logic               r_out_valid;
    logic [2:0]         r_out_chan;
    logic signed [15:0] r_out_sample;

    logic               w_acc;
    logic               w_is_sample;
    logic [ROW_W-1:0]   w_row;
    logic               w_row_val;
    logic               w_band_on;
    logic               w_coef_we;
    logic [CA_W-1:0]    w_coef_waddr;
    logic [CA_W-1:0]    w_coef_raddr;
    logic [31:0]        w_coef_rd;
    logic               w_hist_we;
    logic [HA_W-1:0]    w_hist_waddr;
    logic [31:0]        w_hist_wdata;
    logic [HA_W-1:0]    w_hist_raddr;
    logic [31:0]        w_hist_rd;
    logic signed [31:0] w_hist_op;
    logic signed [31:0] w_mac_data;
    logic signed [31:0] w_y;
    t_mac_ctl           w_mac_ctl;
    logic               w_clip_start;
    logic               w_clip_done;
    logic signed [15:0] w_clip_res;
    logic               w_out_free;

    // handshake
    assign i_in.ready       = (r_state == S_IDLE);
    assign w_acc            = i_in.valid && i_in.ready;
    assign w_out_free       = !r_out_valid || o_out.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.chan_out   = r_out_chan;
    assign o_out.sample_out = r_out_sample;

    assign w_is_sample = (t_action'(i_in.action) == ACT_SAMPLE)
                         && (6'(i_in.chan) < 6'(CHANNELS));

    // current history row and its state
    assign w_row     = ROW_W'(ROW_W'(r_chan) * ROW_W'(BANDS) + ROW_W'(r_band));
    assign w_row_val = r_hval[w_row];
    assign w_band_on = r_en[r_band[BI_W-1:0]];

    // coefficient store
    assign w_coef_we    = w_acc && (t_action'(i_in.action) == ACT_COEF)
                          && (4'(i_in.band) < 4'(BANDS))
                          && (i_in.coef_index < 3'(NCOEF));
    assign w_coef_waddr = CA_W'(CA_W'(i_in.band) * CA_W'(NCOEF)
                          + CA_W'(i_in.coef_index));
    assign w_coef_raddr = CA_W'(CA_W'(r_band) * CA_W'(NCOEF) + CA_W'(r_cnt));

    tbeq_ram #(.W(32), .D(COEF_D)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (w_coef_waddr),
        .i_wdata (i_in.coef_value),
        .i_raddr (w_coef_raddr),
        .o_rdata (w_coef_rd)
    );

    // history store: x1, x2, y1, y2 per channel and band
    assign w_hist_raddr = {w_row, 2'(r_cnt - 3'd1)};
    assign w_hist_we    = (r_state == S_WB);
    assign w_hist_waddr = {w_row, r_cnt[1:0]};

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    w_hist_wdata = r_x;
            2'd1:    w_hist_wdata = r_h0;
            2'd2:    w_hist_wdata = w_y;
            default: w_hist_wdata = r_h2;
        endcase
    end

    tbeq_ram #(.W(32), .D(HIST_D)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (w_hist_waddr),
        .i_wdata (w_hist_wdata),
        .i_raddr (w_hist_raddr),
        .o_rdata (w_hist_rd)
    );

    // rows never written since reset or clearing read as zero
    assign w_hist_op  = w_row_val ? w_hist_rd : 32'sd0;
    assign w_mac_data = (r_cnt == 3'd1) ? r_x : w_hist_op;

    always_comb begin
        w_mac_ctl.clr = (r_state == S_BAND);
        w_mac_ctl.en  = (r_state == S_MAC) && (r_cnt != 3'd0);
        w_mac_ctl.sub = (r_cnt == 3'd4) || (r_cnt == 3'd5);
    end

    tbeq_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_coef  (w_coef_rd),
        .i_data  (w_mac_data),
        .o_y     (w_y)
    );

    assign w_clip_start = (r_state == S_BAND) && (r_band == BC_W'(BANDS)) && r_touched;

    tbeq_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_clip_start),
        .i_v     (r_x),
        .o_done  (w_clip_done),
        .o_res   (w_clip_res)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc && w_is_sample) n_state = S_BAND;
            end
            S_BAND: begin
                if (r_band == BC_W'(BANDS)) begin
                    n_state = r_touched ? S_CLIP : S_OUT;
                end else if (w_band_on) begin
                    n_state = S_MAC;
                end
            end
            S_MAC:   if (r_cnt == 3'd5) n_state = S_DRAIN;
            S_DRAIN: n_state = S_WB;
            S_WB:    if (r_cnt == 3'd3) n_state = S_BAND;
            S_CLIP:  if (w_clip_done) n_state = S_OUT;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers: enables, history valid bits, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en        <= '0;
            r_hval      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc && (t_action'(i_in.action) == ACT_ENABLE)) begin
                for (int b = 0; b < BANDS; b++) begin
                    if (4'(i_in.band) == 4'(b)) r_en[b] <= i_in.band_on;
                end
            end
            if (r_state == S_BAND && r_band != BC_W'(BANDS) && !w_band_on) begin
                r_hval[w_row] <= 1'b0;
            end
            if (r_state == S_WB && r_cnt == 3'd3) begin
                r_hval[w_row] <= 1'b1;
            end
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_chan    <= i_in.chan;
                r_sample  <= i_in.sample_in;
                r_x       <= 32'(i_in.sample_in) <<< 9;
                r_band    <= '0;
                r_touched <= 1'b0;
                r_cnt     <= '0;
            end
            S_BAND: begin
                r_cnt <= '0;
                if (r_band != BC_W'(BANDS) && !w_band_on) begin
                    r_band <= r_band + BC_W'(1);
                end
                if (r_band == BC_W'(BANDS)) begin
                    r_res <= r_sample;
                end
            end
            S_MAC: begin
                r_cnt <= (r_cnt == 3'd5) ? 3'd0 : r_cnt + 3'd1;
                if (r_cnt == 3'd2) r_h0 <= w_hist_op;
                if (r_cnt == 3'd4) r_h2 <= w_hist_op;
            end
            S_WB: begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    r_x       <= w_y;
                    r_band    <= r_band + BC_W'(1);
                    r_touched <= 1'b1;
                end
            end
            S_CLIP: begin
                if (w_clip_done) r_res <= w_clip_res;
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out_chan   <= r_chan;
                    r_out_sample <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire
